[rtl/seven_segment_scan_driver_top_assert.svh]
// Assertion macros for the checker file of this block.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssd assertion failed");

`endif

[rtl/ssd_pkg.sv]
package ssd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam logic [7:0] DP_BIT   = 8'h80;
  localparam logic [7:0] SEG_MASK = 8'h7f;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_DP_ON  = 3'd2,
    OP_DP_OFF = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // One registered item between the decode stage and the pattern store.
  typedef struct packed {
    logic       valid;
    logic [2:0] op;
    logic [1:0] digit;
    logic [7:0] glyph;
  } item_t;

endpackage

[rtl/ssd_decode.sv]
module ssd_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [2:0]    operation_i,
  input  logic [1:0]    digit_i,
  input  logic [7:0]    char_code_i,
  input  logic          hold_i,
  output logic          in_stall_o,
  output ssd_pkg::item_t item_o
);
  import ssd_pkg::*;

  logic       valid_q;
  logic [2:0] op_q;
  logic [1:0] digit_q;
  logic [7:0] glyph_q, glyph_d;

  // ASCII to gfedcba; anything not in the table is blank.
  always_comb begin
    unique case (char_code_i)
      8'h30:   glyph_d = 8'h3f;
      8'h31:   glyph_d = 8'h06;
      8'h32:   glyph_d = 8'h5b;
      8'h33:   glyph_d = 8'h4f;
      8'h34:   glyph_d = 8'h66;
      8'h35:   glyph_d = 8'h6d;
      8'h36:   glyph_d = 8'h7d;
      8'h37:   glyph_d = 8'h07;
      8'h38:   glyph_d = 8'h7f;
      8'h39:   glyph_d = 8'h6f;
      8'h61:   glyph_d = 8'h77;
      8'h62:   glyph_d = 8'h7c;
      8'h63:   glyph_d = 8'h39;
      8'h64:   glyph_d = 8'h5e;
      8'h65:   glyph_d = 8'h79;
      8'h2a:   glyph_d = 8'h46;
      8'h23:   glyph_d = 8'h70;
      default: glyph_d = 8'h00;
    endcase
  end

  assign in_stall_o = valid_q & hold_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= operation_i;
      digit_q <= digit_i;
      glyph_q <= glyph_d & SEG_MASK;
    end
  end

  assign item_o = '{valid: valid_q, op: op_q, digit: digit_q, glyph: glyph_q};

endmodule

[rtl/ssd_scan.sv]
module ssd_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssd_pkg::item_t item_i,
  output logic           hold_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     segments_o,
  output logic [3:0]     digit_enable_o
);
  import ssd_pkg::*;

  logic [7:0]        pat_q [NUM_DIGITS];
  logic [7:0]        pat_d [NUM_DIGITS];
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [SCAN_W-1:0] didx;
  logic              dig_ok;
  logic              fire;
  logic              tick;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        seg_q, seg_d;
  logic [3:0]        en_q, en_d;

  // A tick waits only while the result register holds an untaken transaction.
  assign hold_o = item_i.valid && (item_i.op == OP_TICK) && out_valid_q && out_stall_i;
  assign fire   = item_i.valid && !hold_o;
  assign dig_ok = 32'(item_i.digit) < NUM_DIGITS;
  assign didx   = SCAN_W'(item_i.digit);

  always_comb begin
    pat_d  = pat_q;
    scan_d = scan_q;
    tick   = 1'b0;
    seg_d  = seg_q;
    en_d   = en_q;
    if (fire) begin
      unique case (item_i.op)
        OP_TICK: begin
          tick  = 1'b1;
          seg_d = pat_q[scan_q];
          if (32'(scan_q) < 4) begin
            en_d = ~(4'b0001 << scan_q);
          end else begin
            en_d = 4'hf;
          end
          if (32'(scan_q) == NUM_DIGITS - 1) begin
            scan_d = '0;
          end else begin
            scan_d = scan_q + SCAN_W'(1);
          end
        end
        OP_SET: begin
          if (dig_ok) begin
            pat_d[didx] = item_i.glyph | (pat_q[didx] & DP_BIT);
          end
        end
        OP_DP_ON: begin
          if (dig_ok) begin
            pat_d[didx] = pat_q[didx] | DP_BIT;
          end
        end
        OP_DP_OFF: begin
          if (dig_ok) begin
            pat_d[didx] = pat_q[didx] & SEG_MASK;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            pat_d[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_d = tick | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        pat_q[i] <= '0;
      end
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pat_q       <= pat_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    en_q  <= en_d;
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = seg_q;
  assign digit_enable_o = en_q;

endmodule

[rtl/seven_segment_scan_driver_top.sv]
// Multiplexed seven-segment driver for four digits. Each input transaction is one
// operation: tick, set character, decimal point on or off, or clear. Only a tick
// produces an output transaction, carrying the scanned digit's pattern (gfedcba,
// bit 7 decimal point) and its active-low enable, after which the scan moves on
// to the next digit. One transaction is accepted per cycle while input stall is
// low; an item passes an input register and then the result register, from
// which a tick's result is shown on the output until the sink takes it. Input
// stall rises only when a tick is waiting behind an output transaction that the
// sink has not yet taken.
module seven_segment_scan_driver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [1:0] digit_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] segments_o,
  output logic [3:0] digit_enable_o
);
  import ssd_pkg::*;

  item_t item;
  logic  hold;

  ssd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .digit_i     (digit_i),
    .char_code_i (char_code_i),
    .hold_i      (hold),
    .in_stall_o  (in_stall_o),
    .item_o      (item)
  );

  ssd_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .hold_o         (hold),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_enable_o (digit_enable_o)
  );

endmodule

[rtl/ssd_checker.sv]
`include "seven_segment_scan_driver_top_assert.svh"

module ssd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] segments_o,
  input logic [3:0] digit_enable_o
);

  // Exactly one digit is driven in every result.
  `SSD_ASSERT_SAME(a_one_enable, out_valid_o, $onehot(~digit_enable_o))

  // The input side is held back only by a result the sink has not taken.
  `SSD_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // A stalled output transaction keeps its payload.
  `SSD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(segments_o) && $stable(digit_enable_o))

endmodule

bind seven_segment_scan_driver_top ssd_checker u_ssd_checker (.*);

[test/seven_segment_scan_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the scan driver. It keeps its own copy of the digit
// patterns and the scan position, queues one expected frame per accepted tick,
// and compares every accepted output transaction with the oldest frame queued.
module seven_segment_scan_checker
  import ssd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] operation_i,
  input  logic [1:0] digit_i,
  input  logic [7:0] char_code_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] segments_i,
  input  logic [3:0] digit_enable_i,
  output int         errors_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_enable;
  } scan_frame_t;

  logic [7:0]        shown [NUM_DIGITS];
  logic [SCAN_W-1:0] scan_pos;
  scan_frame_t       frames_due [$];
  int                mismatch_total;

  function automatic logic [7:0] char_glyph(input logic [7:0] ch);
    case (ch)
      "0": return 8'h3f;
      "1": return 8'h06;
      "2": return 8'h5b;
      "3": return 8'h4f;
      "4": return 8'h66;
      "5": return 8'h6d;
      "6": return 8'h7d;
      "7": return 8'h07;
      "8": return 8'h7f;
      "9": return 8'h6f;
      "a": return 8'h77;
      "b": return 8'h7c;
      "c": return 8'h39;
      "d": return 8'h5e;
      "e": return 8'h79;
      "*": return 8'h46;
      "#": return 8'h70;
      default: return 8'h00;
    endcase
  endfunction

  task automatic apply_op(input logic [2:0] op, input logic [1:0] dg, input logic [7:0] ch);
    scan_frame_t frame;
    int          nxt;
    case (op)
      OP_TICK: begin
        frame.segments     = shown[scan_pos];
        frame.digit_enable = (scan_pos < 4) ? ~(4'b0001 << scan_pos) : 4'hf;
        frames_due.push_back(frame);
        nxt = int'(scan_pos) + 1;
        scan_pos = (nxt >= NUM_DIGITS) ? '0 : SCAN_W'(nxt);
      end
      OP_SET: begin
        if (dg < NUM_DIGITS) shown[dg] = (char_glyph(ch) & SEG_MASK) | (shown[dg] & DP_BIT);
      end
      OP_DP_ON: begin
        if (dg < NUM_DIGITS) shown[dg] = shown[dg] | DP_BIT;
      end
      OP_DP_OFF: begin
        if (dg < NUM_DIGITS) shown[dg] = shown[dg] & SEG_MASK;
      end
      OP_CLEAR: begin
        foreach (shown[i]) shown[i] = 8'h00;
      end
      default: begin
        // Unused operation codes leave everything as it is.
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_frame_t want;
    if (!rst_ni) begin
      foreach (shown[i]) shown[i] = 8'h00;
      scan_pos = '0;
      frames_due.delete();
      mismatch_total = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      // A result can only stem from a tick accepted at an earlier edge, so
      // comparing before predicting this edge's input is safe.
      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          $error("unexpected output transaction: segments %h, digit_enable %h",
                 segments_i, digit_enable_i);
          mismatch_total++;
        end else begin
          want = frames_due.pop_front();
          if (segments_i !== want.segments) begin
            $error("segments: expected %h, actual %h", want.segments, segments_i);
            mismatch_total++;
          end
          if (digit_enable_i !== want.digit_enable) begin
            $error("digit_enable: expected %h, actual %h", want.digit_enable, digit_enable_i);
            mismatch_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_op(operation_i, digit_i, char_code_i);
      errors_o <= mismatch_total;
      pending_o <= frames_due.size();
    end
  end

endmodule

[test/tb_seven_segment_scan_driver_top.sv]
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver_top;
  import ssd_pkg::*;

  localparam int         HALF_PERIOD     = 6;
  localparam int         RESET_CYCLES    = 4;
  localparam int         ITEMS_PER_PHASE = 150;
  localparam int         LONG_HOLD       = 40;
  localparam int         DRAIN_CYCLES    = 10;
  localparam int         TIMEOUT_NS      = 2_400_000;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [2:0] operation_i    = OP_TICK;
  logic [1:0] digit_i        = 2'd0;
  logic [7:0] char_code_i    = 8'h00;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] segments_o;
  logic [3:0] digit_enable_o;

  int check_errors;
  int check_pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_seq    = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  seven_segment_scan_driver_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .digit_i        (digit_i),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_enable_o (digit_enable_o)
  );

  seven_segment_scan_checker scan_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation_i),
    .digit_i        (digit_i),
    .char_code_i    (char_code_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_i     (segments_o),
    .digit_enable_i (digit_enable_o),
    .errors_o       (check_errors),
    .pending_o      (check_pending)
  );

  // Sink side: random stalls, or a counted hold-off whenever hold_seq moves.
  initial begin : sink
    int seen;
    int hold_left;
    seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  function automatic logic [2:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_TICK;
    if (r < 70) return OP_SET;
    if (r < 80) return OP_DP_ON;
    if (r < 90) return OP_DP_OFF;
    if (r < 94) return OP_CLEAR;
    return 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
  endfunction

  // Mostly characters the decoder knows, the rest anywhere in the byte range.
  function automatic logic [7:0] random_char();
    int k;
    if ($urandom_range(0, 9) >= 6) return 8'($urandom_range(0, 255));
    k = $urandom_range(0, 17);
    if (k < 10) return 8'("0" + k);
    if (k < 15) return 8'("a" + k - 10);
    if (k == 15) return "*";
    if (k == 16) return "#";
    return " ";
  endfunction

  // Presents one transaction and returns at the edge where it is accepted.
  task automatic offer(input logic [2:0] op, input logic [1:0] dg, input logic [7:0] ch);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    digit_i     <= dg;
    char_code_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (check_pending != 0);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Blank display after reset, one full scan.
    repeat (4) offer(OP_TICK, 2'd0, 8'h00);
    offer(OP_SET, 2'd0, "0");
    offer(OP_SET, 2'd1, "9");
    offer(OP_SET, 2'd2, "a");
    offer(OP_SET, 2'd3, "e");
    offer(OP_DP_ON, 2'd0, 8'h00);
    offer(OP_DP_ON, 2'd3, 8'hff);
    // The decimal point survives a new character, known or not.
    offer(OP_SET, 2'd0, "*");
    offer(OP_SET, 2'd1, "#");
    offer(OP_SET, 2'd2, 8'hff);
    offer(OP_SET, 2'd3, " ");
    offer(OP_FIRST_UNUSED, 2'd1, "8");
    offer(OP_LAST_UNUSED, 2'd2, "8");
    offer(OP_DP_OFF, 2'd3, 8'h00);
    repeat (4) offer(OP_TICK, 2'd3, 8'hff);
    offer(OP_CLEAR, 2'd0, 8'h00);
    repeat (2) offer(OP_TICK, 2'd0, 8'h00);

    // Sender pauses until every result is out.
    wait_drained();

    // Long sink hold-off while ticks keep coming, so the input backs up.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_seq <= hold_seq + 1;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 0) offer(OP_SET, 2'(n % 4), random_char());
      else offer(OP_TICK, 2'(n % 4), 8'h00);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct <= 86;
        end
        1: begin
          tx_idle_pct = 86;
          rx_idle_pct <= 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) offer(random_op(), 2'($urandom_range(0, 3)), random_char());
    end

    rx_idle_pct <= 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (check_errors == 0 && check_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
